@@ hdl/gmp_pkg.sv @@
package gmp_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int ROW_LIMIT   = 1024;
    localparam int VALUE_BITS  = 16;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(ROW_LIMIT);
    localparam int SIZE_BITS   = 11;
    localparam int COORD_BITS  = 9;
    localparam int CFG_IDX_BITS = 1;

    typedef logic [VALUE_BITS-1:0] value_t;

    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT = 1'b1;

    function automatic value_t min_value(input value_t a, input value_t b);
        return (a < b) ? a : b;
    endfunction

endpackage

@@ hdl/gmp_ram.sv @@
module gmp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/grid_min_pool_3x3_stride2.sv @@
// 3x3 min pooling with stride 2 over a streamed cost grid.
// input channel: one source cell per beat (cell_value, unsigned q8.8), row-major,
// in_valid / in_stall. output channel: one coarse cell per beat with its
// coarse column and row, frame_done on the last coarse cell of the frame,
// out_valid / out_stall. an input beat yields zero or one output beat.
// config channel: cfg_valid / cfg_ready with cfg_index (0 width, 1 height)
// and cfg_data; cfg_ready is always high. write only while the block is idle.
// throughput: one input beat per cycle while in_stall is low, set by the single
// read-modify-write pass through the two line stores (one read and one write port
// each). an accepted cell and its line store reads are registered in the compare
// stage; its result, if any, then goes to the output register behind out_valid.
// when the receiver stalls, a held result blocks the compare stage only if
// that stage also has a result; then in_stall rises and the pipeline freezes.
// reset clears counters and valid bits, sets the geometry to 1024 x 1024;
// the line stores are not cleared and need no clearing pass.
module grid_min_pool_3x3_stride2 (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [gmp_pkg::VALUE_BITS-1:0]        cell_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [gmp_pkg::VALUE_BITS-1:0]        pooled_value,
    output logic [gmp_pkg::COORD_BITS-1:0]        out_column,
    output logic [gmp_pkg::COORD_BITS-1:0]        out_row,
    output logic                                  frame_done,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gmp_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [gmp_pkg::SIZE_BITS-1:0]         cfg_data
);

    logic [gmp_pkg::SIZE_BITS-1:0] width_cfg_reg;
    logic [gmp_pkg::SIZE_BITS-1:0] height_cfg_reg;
    logic [gmp_pkg::SIZE_BITS-1:0] width_eff;
    logic [gmp_pkg::SIZE_BITS-1:0] height_eff;

    logic [gmp_pkg::COL_BITS-1:0]  col_cnt_reg;
    logic [gmp_pkg::ROW_BITS-1:0]  row_cnt_reg;
    logic [gmp_pkg::COL_BITS-1:0]  col_cnt_next;
    logic [gmp_pkg::ROW_BITS-1:0]  row_cnt_next;
    logic                          last_col_in;
    logic                          last_row_in;
    logic                          accept;

    logic                          s1_valid_reg;
    gmp_pkg::value_t               s1_value_reg;
    logic [gmp_pkg::COL_BITS-1:0]  s1_col_reg;
    logic [gmp_pkg::ROW_BITS-1:0]  s1_row_reg;
    logic                          s1_last_col_reg;
    logic                          s1_last_row_reg;
    logic                          s1_blocked;
    logic                          s1_fire;

    gmp_pkg::value_t               hp_reg;
    gmp_pkg::value_t               hp_next;

    gmp_pkg::value_t               cpm_rd_data;
    gmp_pkg::value_t               carry_rd_data;
    logic                          cpm_we;
    logic                          carry_we;
    logic                          cpm_wr_en;
    logic                          carry_wr_en;

    logic                          byp_cpm_reg;
    logic                          byp_carry_reg;
    gmp_pkg::value_t               byp_cpm_data_reg;
    gmp_pkg::value_t               byp_carry_data_reg;

    gmp_pkg::value_t               cpm_val;
    gmp_pkg::value_t               carry_val;
    gmp_pkg::value_t               part;
    gmp_pkg::value_t               vv;
    gmp_pkg::value_t               hm;
    gmp_pkg::value_t               res;
    logic                          have_v;
    logic                          s1_emit;

    logic                          out_valid_reg;
    gmp_pkg::value_t               out_value_reg;
    logic [gmp_pkg::COORD_BITS-1:0] out_col_reg;
    logic [gmp_pkg::COORD_BITS-1:0] out_row_reg;
    logic                          out_done_reg;

    // config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= gmp_pkg::SIZE_BITS'(gmp_pkg::MAX_WIDTH);
            height_cfg_reg <= gmp_pkg::SIZE_BITS'(gmp_pkg::ROW_LIMIT);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gmp_pkg::REG_GRID_WIDTH:  width_cfg_reg  <= cfg_data;
                gmp_pkg::REG_GRID_HEIGHT: height_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (width_cfg_reg == '0)
            width_eff = gmp_pkg::SIZE_BITS'(1);
        else if (width_cfg_reg > gmp_pkg::SIZE_BITS'(gmp_pkg::MAX_WIDTH))
            width_eff = gmp_pkg::SIZE_BITS'(gmp_pkg::MAX_WIDTH);
        else
            width_eff = width_cfg_reg;
        if (height_cfg_reg == '0)
            height_eff = gmp_pkg::SIZE_BITS'(1);
        else if (height_cfg_reg > gmp_pkg::SIZE_BITS'(gmp_pkg::ROW_LIMIT))
            height_eff = gmp_pkg::SIZE_BITS'(gmp_pkg::ROW_LIMIT);
        else
            height_eff = height_cfg_reg;
    end

    // input stage: counters and line store read
    assign in_stall = s1_valid_reg && s1_blocked;
    assign accept   = in_valid && !in_stall;

    assign last_col_in = (gmp_pkg::SIZE_BITS'(col_cnt_reg) + gmp_pkg::SIZE_BITS'(1)) >= width_eff;
    assign last_row_in = (gmp_pkg::SIZE_BITS'(row_cnt_reg) + gmp_pkg::SIZE_BITS'(1)) >= height_eff;

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (accept)
        begin
            if (last_col_in)
            begin
                col_cnt_next = '0;
                row_cnt_next = last_row_in ? '0 : row_cnt_reg + gmp_pkg::ROW_BITS'(1);
            end
            else
            begin
                col_cnt_next = col_cnt_reg + gmp_pkg::COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            if (!in_stall)
            begin
                s1_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_value_reg    <= cell_value;
            s1_col_reg      <= col_cnt_reg;
            s1_row_reg      <= row_cnt_reg;
            s1_last_col_reg <= last_col_in;
            s1_last_row_reg <= last_row_in;
        end
    end

    gmp_ram #(
        .WIDTH (gmp_pkg::VALUE_BITS),
        .DEPTH (gmp_pkg::MAX_WIDTH)
    ) u_cpm_ram (
        .clk     (clk),
        .wr_en   (cpm_wr_en),
        .wr_addr (s1_col_reg),
        .wr_data (part),
        .rd_en   (accept),
        .rd_addr (col_cnt_reg),
        .rd_data (cpm_rd_data)
    );

    gmp_ram #(
        .WIDTH (gmp_pkg::VALUE_BITS),
        .DEPTH (gmp_pkg::MAX_WIDTH)
    ) u_carry_ram (
        .clk     (clk),
        .wr_en   (carry_wr_en),
        .wr_addr (s1_col_reg),
        .wr_data (s1_value_reg),
        .rd_en   (accept),
        .rd_addr (col_cnt_reg),
        .rd_data (carry_rd_data)
    );

    // forward a write that lands on the entry being read in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_cpm_reg   <= 1'b0;
            byp_carry_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            byp_cpm_reg   <= accept && cpm_wr_en && (s1_col_reg == col_cnt_reg);
            byp_carry_reg <= accept && carry_wr_en && (s1_col_reg == col_cnt_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            byp_cpm_data_reg   <= part;
            byp_carry_data_reg <= s1_value_reg;
        end
    end

    // compare stage
    always_comb
    begin
        cpm_val   = byp_cpm_reg ? byp_cpm_data_reg : cpm_rd_data;
        carry_val = byp_carry_reg ? byp_carry_data_reg : carry_rd_data;
        part      = (s1_row_reg == '0) ? s1_value_reg
                                       : gmp_pkg::min_value(carry_val, s1_value_reg);
        cpm_we    = 1'b0;
        carry_we  = 1'b0;
        vv        = part;
        have_v    = 1'b0;
        if (!s1_row_reg[0])
        begin
            have_v = s1_last_row_reg;
            cpm_we = !s1_last_row_reg;
        end
        else
        begin
            vv       = gmp_pkg::min_value(cpm_val, s1_value_reg);
            carry_we = 1'b1;
            have_v   = 1'b1;
        end

        hm      = (s1_col_reg == '0) ? vv : gmp_pkg::min_value(hp_reg, vv);
        res     = hm;
        s1_emit = 1'b0;
        hp_next = hp_reg;
        if (have_v)
        begin
            if (!s1_col_reg[0])
            begin
                if (s1_last_col_reg)
                    s1_emit = 1'b1;
                else
                    hp_next = hm;
            end
            else
            begin
                res     = gmp_pkg::min_value(hp_reg, vv);
                hp_next = vv;
                s1_emit = 1'b1;
            end
        end
        if (s1_last_col_reg)
        begin
            hp_next = '1;
        end
    end

    assign s1_blocked  = s1_emit && out_valid_reg && out_stall;
    assign s1_fire     = s1_valid_reg && !s1_blocked;
    assign cpm_wr_en   = s1_fire && cpm_we;
    assign carry_wr_en = s1_fire && carry_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_reg <= '1;
        end
        else if (s1_fire)
        begin
            hp_reg <= hp_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_emit)
        begin
            out_value_reg <= res;
            out_col_reg   <= s1_col_reg[gmp_pkg::COORD_BITS:1];
            out_row_reg   <= s1_row_reg[gmp_pkg::COORD_BITS:1];
            out_done_reg  <= s1_last_col_reg && s1_last_row_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pooled_value = out_value_reg;
    assign out_column   = out_col_reg;
    assign out_row      = out_row_reg;
    assign frame_done   = out_done_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled without a held result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (byp_cpm_reg || byp_carry_reg) |-> s1_valid_reg)
        else $error("forwarding flag without an item in the compare stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_emit |=> out_valid_reg)
        else $error("result lost between compare stage and output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_col_in |=> col_cnt_reg == '0)
        else $error("column counter did not wrap at the end of a row");
`endif

endmodule
